[rtl/clsm_pkg.sv]
// types, constants and codes shared by the channel latency statistics monitor
// no dependencies; imported by every module of the block
package clsm_pkg;

   localparam int CHAN_W     = 4;
   localparam int DUR_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int TOTAL_W    = 48;
   localparam int THR_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [THR_W-1:0]   WARMUP_RESET = 8'd5;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [DUR_W-1:0]   DUR_ONES     = {DUR_W{1'b1}};

   // register index within the csr space (paddr[2])
   localparam logic REG_WARMUP = 1'b0;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [DUR_W-1:0]  duration;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel_echo;
      logic [COUNT_W-1:0] sample_count;
      logic [TOTAL_W-1:0] total_time;
      logic [DUR_W-1:0]   min_time;
      logic [DUR_W-1:0]   max_time;
      logic [COUNT_W-1:0] min_at_sample;
      logic [COUNT_W-1:0] max_at_sample;
      logic               new_minimum;
      logic               new_maximum;
   } rsp_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] count;
      logic [DUR_W-1:0]   minimum;
      logic [DUR_W-1:0]   maximum;
      logic [COUNT_W-1:0] min_index;
      logic [COUNT_W-1:0] max_index;
   } row_type;

   localparam row_type ROW_RESET = '{
      total:     '0,
      count:     '0,
      minimum:   DUR_ONES,
      maximum:   '0,
      min_index: '0,
      max_index: '0
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;  // transaction accepted: latch payload, start row read
      logic update;   // compute statistics and load result register
      logic write;    // write updated row back
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_range;
   } sts_type;

endpackage

[rtl/clsm_ctrl.sv]
// controller state machine of the channel latency statistics monitor
// depends on clsm_pkg; drives clsm_datapath through cmd_type / sts_type
module clsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output clsm_pkg::cmd_type cmd,
   input  clsm_pkg::sts_type sts
);
   import clsm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.update  = 1'b0;
      cmd.write   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_CALC: begin
            cmd.update = 1'b1;
            cmd.write  = sts.in_range;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

[rtl/clsm_datapath.sv]
// statistics table and update arithmetic of the channel latency monitor
// depends on clsm_pkg; sequenced by clsm_ctrl
module clsm_datapath #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  clsm_pkg::req_type               req_data,
   input  logic [clsm_pkg::THR_W-1:0]      warmup_threshold,
   input  clsm_pkg::cmd_type               cmd,
   output clsm_pkg::sts_type               sts,
   output clsm_pkg::rsp_type               rsp_data
);
   import clsm_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   row_type                 row_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] row_valid_ff;

   req_type          item_ff;
   logic             in_range_ff;
   row_type          rd_row_ff;
   logic             rd_valid_ff;
   rsp_type          rsp_ff;

   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             req_in_range;
   row_type          row_cur;
   row_type          row_new;
   logic [TOTAL_W:0] sum;
   logic             track;
   logic             new_min;
   logic             new_max;
   rsp_type          rsp_in;

   assign rd_idx       = IDX_W'(req_data.channel);
   assign wr_idx       = IDX_W'(item_ff.channel);
   assign req_in_range = 9'(req_data.channel) < 9'(NUM_CHANNELS);

   // table: one read at capture, one write at update
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_row_ff   <= row_mem[rd_idx];
         rd_valid_ff <= row_valid_ff[rd_idx];
         item_ff     <= req_data;
         in_range_ff <= req_in_range;
      end
      if (cmd.write) begin
         row_mem[wr_idx] <= row_new;
      end
   end

   // rows never written read back as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.write) begin
         row_valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_comb begin
      row_cur = rd_valid_ff ? rd_row_ff : ROW_RESET;
      row_new = row_cur;

      sum           = {1'b0, row_cur.total} + (TOTAL_W + 1)'(item_ff.duration);
      row_new.total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

      if (row_cur.count != COUNT_MAX) begin
         row_new.count = row_cur.count + COUNT_W'(1);
      end

      track   = row_new.count >= COUNT_W'(warmup_threshold);
      new_min = track && (item_ff.duration < row_cur.minimum);
      new_max = track && (item_ff.duration > row_cur.maximum);

      if (new_min) begin
         row_new.minimum   = item_ff.duration;
         row_new.min_index = row_new.count;
      end
      if (new_max) begin
         row_new.maximum   = item_ff.duration;
         row_new.max_index = row_new.count;
      end

      rsp_in              = '0;
      rsp_in.channel_echo = item_ff.channel;
      rsp_in.min_time     = DUR_ONES;
      if (in_range_ff) begin
         rsp_in.sample_count  = row_new.count;
         rsp_in.total_time    = row_new.total;
         rsp_in.min_time      = row_new.minimum;
         rsp_in.max_time      = row_new.maximum;
         rsp_in.min_at_sample = row_new.min_index;
         rsp_in.max_at_sample = row_new.max_index;
         rsp_in.new_minimum   = new_min;
         rsp_in.new_maximum   = new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.in_range = in_range_ff;
   assign rsp_data     = rsp_ff;

endmodule

[rtl/channel_latency_stats_monitor_top.sv]
// top level of the channel latency statistics monitor: csr port and wiring
// depends on clsm_pkg, clsm_ctrl and clsm_datapath
//
//   port group   direction   handshake         payload
//   req_*        in          req_valid/stall   req_data   (channel, duration)
//   rsp_*        out         rsp_valid/stall   rsp_data   (updated statistics)
//   apb          in          psel/penable      warmup_threshold at 0x0
//
// one transaction at a time through idle, calc and resp: read of the channel row,
// update and write-back, then the result register waits to be taken
// the controller sets the pace: a new request is taken only in idle
// synchronous reset marks every row as unwritten (reads as reset values)
// and sets warmup_threshold to 5; no clearing pass is needed
// req_stall stays high from acceptance until the result is taken
module channel_latency_stats_monitor_top #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  clsm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output clsm_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [clsm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [clsm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [clsm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import clsm_pkg::*;

   logic [THR_W-1:0] warmup_ff;
   logic             csr_write;
   cmd_type          cmd;
   sts_type          sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_ff <= WARMUP_RESET;
      end else if (csr_write && (paddr[2] == REG_WARMUP)) begin
         warmup_ff <= pwdata[THR_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_WARMUP) begin
         prdata = CSR_DATA_W'(warmup_ff);
      end
   end

   clsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   clsm_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .warmup_threshold (warmup_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_data         (rsp_data)
   );

   // a fresh extreme is stamped with the updated sample count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_minimum |-> rsp_data.min_at_sample == rsp_data.sample_count)
      else $error("new minimum not stamped with sample count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_maximum |-> rsp_data.max_at_sample == rsp_data.sample_count)
      else $error("new maximum not stamped with sample count");

   // only one transaction in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a transaction is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_minimum |-> rsp_data.min_time <= rsp_data.max_time)
      else $error("new minimum above stored maximum");

endmodule
